// ----- hdl/directional_diff_score_macros.svh -----
// ----------------------------------------------------------------------------
// directional_diff_score_macros
// Assertion macros for the directional score block. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DIRECTIONAL_DIFF_SCORE_MACROS_SVH
`define DIRECTIONAL_DIFF_SCORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition that must hold at every clock edge outside reset
`define DDS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dds: invariant violated");
// Check that the consequent holds in the same cycle as the antecedent
`define DDS_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dds: same-cycle implication violated");
// Check that the consequent holds in the cycle after the antecedent
`define DDS_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dds: next-cycle implication violated");
`else
`define DDS_ASSERT(label, prop)
`define DDS_IMPLIES(label, ante, cons)
`define DDS_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/dds_pkg.sv -----
// ----------------------------------------------------------------------------
// dds_pkg
// Shared sizes, types and codes of the directional difference score block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dds_pkg;

	localparam int MAX_COLS    = 1024;
	localparam int MAX_LINES   = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int COL_BITS    = $clog2(MAX_COLS);
	localparam int LINE_BITS   = $clog2(MAX_LINES);
	localparam int SIZE_BITS   = 11;
	localparam int SCORE_BITS  = 18;
	localparam int DIR_BITS    = 3;
	localparam int MIN_SIZE    = 3;
	localparam int BORDER      = 2;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [DIR_BITS-1:0]    dir_t;
	typedef logic [SIZE_BITS-1:0]   size_t;
	typedef logic signed [SCORE_BITS-1:0] score_t;

	// Direction codes
	localparam dir_t DIR_NONE    = 3'd0;
	localparam dir_t DIR_DIAG_PL = 3'd1;
	localparam dir_t DIR_VERT    = 3'd2;
	localparam dir_t DIR_DIAG_PR = 3'd3;
	localparam dir_t DIR_HORZ    = 3'd4;

	// Register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_POLARITY,
		REG_PREF_DIR,
		REG_COLS,
		REG_LINES
	} reg_idx_t;

	// Two stored lines at one column
	typedef struct packed {
		sample_t top;
		sample_t mid;
	} line_pair_t;

	// One window column, top to bottom
	typedef struct packed {
		sample_t top;
		sample_t mid;
		sample_t cur;
	} column_t;

	// Score result for one interior pixel
	typedef struct packed {
		score_t score;
		dir_t   dir;
	} result_t;

endpackage

// ----- hdl/dds_line_buf.sv -----
// ----------------------------------------------------------------------------
// dds_line_buf
// Two-line buffer kept as one memory word per column, with registered read
// data and forwarding of a write to the same column in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_line_buf (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [dds_pkg::COL_BITS-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [dds_pkg::COL_BITS-1:0] wr_addr,
	input  dds_pkg::line_pair_t      wr_data,
	output dds_pkg::line_pair_t      rd_data
);
	import dds_pkg::*;

	line_pair_t mem [MAX_COLS];
	line_pair_t rd_data_q;

	// Write the column shifted down by one line
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read, forward a same-cycle write to the same column
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/dds_score.sv -----
// ----------------------------------------------------------------------------
// dds_score
// 3x3 window columns and the direction pick and score of its center pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_score (
	input  logic                clk,
	input  logic                shift_en,
	input  dds_pkg::column_t    col_in,
	input  dds_pkg::dir_t       pref_dir,
	output dds_pkg::result_t    result
);
	import dds_pkg::*;

	// older_q is the left column, newer_q the middle one; col_in is the right
	column_t older_q;
	column_t newer_q;

	sample_t center;
	sample_t cand [4];
	sample_t best;
	dir_t    pick;
	dir_t    dir_prev;
	dir_t    dir_next;
	score_t  center_ext;

	// Shift the window one column left
	always_ff @(posedge clk) begin
		if (shift_en) begin
			older_q <= newer_q;
			newer_q <= col_in;
		end
	end

	// Pair minimums of the four candidate directions
	always_comb begin
		center  = newer_q.mid;
		cand[0] = (older_q.top < col_in.cur) ? older_q.top : col_in.cur;
		cand[1] = (newer_q.top < newer_q.cur) ? newer_q.top : newer_q.cur;
		cand[2] = (col_in.top < older_q.cur) ? col_in.top : older_q.cur;
		cand[3] = (older_q.mid < col_in.mid) ? older_q.mid : col_in.mid;
	end

	// Pick the first strictly greatest candidate above zero; no direction when the center is zero
	always_comb begin
		best = '0;
		pick = DIR_NONE;
		for (int i = 0; i < 4; i++) begin
			if (cand[i] > best) begin
				best = cand[i];
				pick = DIR_BITS'(i + 1);
			end
		end
		if (center == '0) begin
			pick = DIR_NONE;
		end
	end

	// Weight the center by how the pick relates to the preferred direction
	always_comb begin
		dir_prev   = (pref_dir < DIR_VERT) ? DIR_HORZ : pref_dir - DIR_BITS'(1);
		dir_next   = (pref_dir >= DIR_HORZ) ? DIR_DIAG_PL : pref_dir + DIR_BITS'(1);
		center_ext = score_t'(center);
		result.dir = pick;
		if (pick == DIR_NONE) begin
			result.score = '0;
		end else if (pick == pref_dir) begin
			result.score = (center_ext <<< 1) + center_ext;
		end else if ((pick == dir_prev) || (pick == dir_next)) begin
			result.score = center_ext;
		end else begin
			result.score = -center_ext;
		end
	end

endmodule

// ----- hdl/directional_diff_score.sv -----
// A window's result passes stage 1, then the result register. Throughput: one
// sample per clock when the output does not stall; the line buffer is one read
// and one write per sample, and the result register decouples the output stall
// by one item. Results are produced only for interior pixels (line >= 2, column >= 2).
// Reset clears counters, valid flags and registers (polarity 1, direction 1,
// 1024 columns, 1024 lines); the line buffer holds no reset value.
// ----------------------------------------------------------------------------
// directional_diff_score
// Directional amplitude score over a 3x3 window of kept difference samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "directional_diff_score_macros.svh"

module directional_diff_score (
	input  logic        clk,
	input  logic        arst_n,
	// request in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] diff_sample
	input  logic        s_tuser,   // [0] frame_start
	// result out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [17:0] score, [20:18] direction, [23:21] zero
	output logic        m_tlast,   // frame_done
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dds_pkg::*;

	function automatic sample_t keep_value(input sample_t raw, input logic pos);
		sample_t k;
		if (pos) begin
			k = raw[SAMPLE_BITS-1] ? '0 : raw;
		end else begin
			k = raw[SAMPLE_BITS-1] ? sample_t'(-raw) : '0;
		end
		return k;
	endfunction

	// configuration registers
	logic       pol_q;
	dir_t       pref_q;
	size_t      cols_q;
	size_t      lines_q;
	reg_idx_t   reg_idx;
	logic       cfg_wr;

	// position counters
	logic [COL_BITS-1:0]  col_q;
	logic [LINE_BITS-1:0] line_q;
	logic [COL_BITS-1:0]  c_cur;
	logic [LINE_BITS-1:0] r_cur;
	logic [COL_BITS-1:0]  col_next;
	logic [LINE_BITS-1:0] line_next;
	size_t                ncols;
	size_t                nlines;
	size_t                c_inc;
	size_t                r_inc;
	logic                 emit;
	logic                 last;

	// stage 1 and write-back
	logic                 accept;
	logic                 s1_valid;
	logic                 s1_go;
	sample_t              v_s1;
	logic                 emit_s1;
	logic                 last_s1;
	logic                 wr_en_q;
	logic [COL_BITS-1:0]  wr_addr_q;
	line_pair_t           rd_pair;
	line_pair_t           wr_pair;
	column_t              col_s1;

	// result
	result_t              res;
	logic                 m_valid_q;
	score_t               m_score;
	dir_t                 m_dir;
	logic                 m_last_q;

	// Configuration writes and reads
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q   <= 1'b1;
			pref_q  <= DIR_DIAG_PL;
			cols_q  <= SIZE_BITS'(MAX_COLS);
			lines_q <= SIZE_BITS'(MAX_LINES);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_POLARITY: pol_q   <= pwdata[0];
				REG_PREF_DIR: pref_q  <= pwdata[DIR_BITS-1:0];
				REG_COLS:     cols_q  <= pwdata[SIZE_BITS-1:0];
				REG_LINES:    lines_q <= pwdata[SIZE_BITS-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_POLARITY: prdata = {31'd0, pol_q};
			REG_PREF_DIR: prdata = {{(32-DIR_BITS){1'b0}}, pref_q};
			REG_COLS:     prdata = {{(32-SIZE_BITS){1'b0}}, cols_q};
			REG_LINES:    prdata = {{(32-SIZE_BITS){1'b0}}, lines_q};
			default:      prdata = '0;
		endcase
	end

	// Clamp frame size
	always_comb begin
		if (cols_q < SIZE_BITS'(MIN_SIZE)) begin
			ncols = SIZE_BITS'(MIN_SIZE);
		end else if (cols_q > SIZE_BITS'(MAX_COLS)) begin
			ncols = SIZE_BITS'(MAX_COLS);
		end else begin
			ncols = cols_q;
		end
		if (lines_q < SIZE_BITS'(MIN_SIZE)) begin
			nlines = SIZE_BITS'(MIN_SIZE);
		end else if (lines_q > SIZE_BITS'(MAX_LINES)) begin
			nlines = SIZE_BITS'(MAX_LINES);
		end else begin
			nlines = lines_q;
		end
	end

	// Position of the incoming sample and the next one
	always_comb begin
		c_cur = s_tuser ? '0 : col_q;
		r_cur = s_tuser ? '0 : line_q;
		if (SIZE_BITS'(c_cur) >= ncols) begin
			c_cur = '0;
		end
		if (SIZE_BITS'(r_cur) >= nlines) begin
			r_cur = '0;
		end
		c_inc = SIZE_BITS'(c_cur) + SIZE_BITS'(1);
		r_inc = SIZE_BITS'(r_cur) + SIZE_BITS'(1);
		if (c_inc >= ncols) begin
			col_next  = '0;
			line_next = (r_inc >= nlines) ? '0 : r_inc[LINE_BITS-1:0];
		end else begin
			col_next  = c_inc[COL_BITS-1:0];
			line_next = r_cur;
		end
		emit = (SIZE_BITS'(r_cur) >= SIZE_BITS'(BORDER))
			&& (SIZE_BITS'(c_cur) >= SIZE_BITS'(BORDER));
		last = (SIZE_BITS'(r_cur) == nlines - SIZE_BITS'(1))
			&& (SIZE_BITS'(c_cur) == ncols - SIZE_BITS'(1));
	end

	// Handshake: stage 1 moves when the result register is free or drained
	assign s1_go    = s1_valid && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid || s1_go;
	assign accept   = s_tvalid && s_tready;

	// Advance counters and stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			line_q   <= '0;
			s1_valid <= 1'b0;
			wr_en_q  <= 1'b0;
		end else begin
			wr_en_q <= accept;
			if (accept) begin
				col_q    <= col_next;
				line_q   <= line_next;
				s1_valid <= 1'b1;
			end else if (s1_go) begin
				s1_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1      <= keep_value(s_tdata, pol_q);
			emit_s1   <= emit;
			last_s1   <= last;
			wr_addr_q <= c_cur;
		end
	end

	// Shift the column down one line in the buffer
	assign wr_pair.top = rd_pair.mid;
	assign wr_pair.mid = v_s1;

	dds_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (c_cur),
		.wr_en   (wr_en_q),
		.wr_addr (wr_addr_q),
		.wr_data (wr_pair),
		.rd_data (rd_pair)
	);

	assign col_s1.top = rd_pair.top;
	assign col_s1.mid = rd_pair.mid;
	assign col_s1.cur = v_s1;

	dds_score u_score (
		.clk      (clk),
		.shift_en (s1_go),
		.col_in   (col_s1),
		.pref_dir (pref_q),
		.result   (res)
	);

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_go) begin
			m_valid_q <= emit_s1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit_s1) begin
			m_score  <= res.score;
			m_dir    <= res.dir;
			m_last_q <= last_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'd0, m_dir, m_score};
	assign m_tlast  = m_last_q;

	`DDS_IMPLIES(a_wr_has_item, wr_en_q, s1_valid)
	`DDS_IMPLIES(a_ready_when_empty, !s1_valid, s_tready)
	`DDS_NEXT(a_stalled_item_kept, s1_valid && !s1_go, s1_valid)
	`DDS_NEXT(a_emit_loads_out, s1_go && emit_s1, m_tvalid)
	`DDS_IMPLIES(a_none_scores_zero, m_tvalid, (m_dir == DIR_NONE) == (m_score == '0))

endmodule

// ----- sim/directional_diff_score_checker.sv -----
// ----------------------------------------------------------------------------
// directional_diff_score_checker
// Watches the sample, score and register channels of the directional score
// block. Keeps its own window and line rows, predicts the score of every
// interior pixel and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module directional_diff_score_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] diff_sample
	input  logic        s_tuser,   // [0] frame_start
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [17:0] score, [20:18] direction, [23:21] zero
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          scores_waiting,
	output int          scores_checked
);
	import dds_pkg::*;

	localparam int   PREF_GAIN = 3;
	localparam dir_t PAIR_DIR [4] = '{DIR_DIAG_PL, DIR_VERT, DIR_DIAG_PR, DIR_HORZ};

	typedef struct {
		score_t score;
		dir_t   dir;
		logic   done;
	} pixel_score_t;

	pixel_score_t pending_scores [$];
	pixel_score_t want;

	// register copies
	logic  keep_positive;
	dir_t  pref_dir;
	size_t col_setting;
	size_t line_setting;

	// two stored rows, the 3x3 window and the raster position
	sample_t upper_row [MAX_COLS];
	sample_t middle_row [MAX_COLS];
	sample_t win [3][3];
	int      col_pos;
	int      line_pos;
	int      fail_total;
	int      checked_total;

	function automatic int fit_size(input int v, input int hi);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int lesser(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	// Reduce a raw sample to the magnitude of the selected polarity
	function automatic sample_t kept_magnitude(input sample_t raw);
		if (keep_positive)
			return raw[SAMPLE_BITS-1] ? '0 : raw;
		return raw[SAMPLE_BITS-1] ? sample_t'(-raw) : '0;
	endfunction

	// Shift one sample into the window and queue the score it completes
	task automatic advance_window(input sample_t raw, input logic first);
		int           ncols, nlines, r, c, center, best, sc, pref, lo_dir, hi_dir;
		int           cand [4];
		sample_t      v, top, mid;
		dir_t         dir;
		pixel_score_t res;
		ncols  = fit_size(col_setting, MAX_COLS);
		nlines = fit_size(line_setting, MAX_LINES);
		v = kept_magnitude(raw);
		if (first) begin
			col_pos  = 0;
			line_pos = 0;
		end
		if (col_pos >= ncols)
			col_pos = 0;
		if (line_pos >= nlines)
			line_pos = 0;
		r = line_pos;
		c = col_pos;

		// shift the window left and load the new column
		top = upper_row[c];
		mid = middle_row[c];
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = v;
		upper_row[c]  = mid;
		middle_row[c] = v;

		// score interior pixels only
		if (r >= BORDER && c >= BORDER) begin
			center = win[1][1];
			dir = DIR_NONE;
			sc = 0;
			if (center != 0) begin
				cand[0] = lesser(win[0][0], win[2][2]);
				cand[1] = lesser(win[0][1], win[2][1]);
				cand[2] = lesser(win[0][2], win[2][0]);
				cand[3] = lesser(win[1][0], win[1][2]);
				best = 0;
				for (int i = 0; i < 4; i++) begin
					if (cand[i] > best) begin
						best = cand[i];
						dir = PAIR_DIR[i];
					end
				end
				pref = pref_dir;
				lo_dir = (pref < DIR_VERT) ? DIR_HORZ : pref - 1;
				hi_dir = (pref + 1 > DIR_HORZ) ? DIR_DIAG_PL : pref + 1;
				if (dir != DIR_NONE) begin
					if (dir == pref)
						sc = PREF_GAIN * center;
					else if (dir == lo_dir || dir == hi_dir)
						sc = center;
					else
						sc = -center;
				end
			end
			res.score = score_t'(sc);
			res.dir   = dir;
			res.done  = (r == nlines - 1 && c == ncols - 1);
			pending_scores.push_back(res);
		end

		// advance the raster position, wrapping at the frame end
		col_pos = c + 1;
		if (col_pos >= ncols) begin
			col_pos = 0;
			line_pos = r + 1;
			if (line_pos >= nlines)
				line_pos = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_positive = 1'b1;
			pref_dir      = DIR_DIAG_PL;
			col_setting   = size_t'(MAX_COLS);
			line_setting  = size_t'(MAX_LINES);
			for (int i = 0; i < MAX_COLS; i++) begin
				upper_row[i]  = '0;
				middle_row[i] = '0;
			end
			for (int k = 0; k < 3; k++)
				for (int j = 0; j < 3; j++)
					win[k][j] = '0;
			col_pos  = 0;
			line_pos = 0;
			pending_scores.delete();
			fail_total    = 0;
			checked_total = 0;
			mismatches     <= 0;
			scores_waiting <= 0;
			scores_checked <= 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_POLARITY: keep_positive = pwdata[0];
					REG_PREF_DIR: pref_dir      = pwdata[DIR_BITS-1:0];
					REG_COLS:     col_setting   = pwdata[SIZE_BITS-1:0];
					REG_LINES:    line_setting  = pwdata[SIZE_BITS-1:0];
				endcase
			end

			// compare a delivered score with the oldest prediction
			if (m_tvalid && m_tready) begin
				if (pending_scores.size() == 0) begin
					$error("unexpected score result: tdata %h tlast %b", m_tdata, m_tlast);
					fail_total++;
				end else begin
					want = pending_scores.pop_front();
					checked_total++;
					if (m_tdata[SCORE_BITS-1:0] !== want.score) begin
						$error("score: expected %0d, got %0d", want.score,
							score_t'(m_tdata[SCORE_BITS-1:0]));
						fail_total++;
					end
					if (m_tdata[SCORE_BITS +: DIR_BITS] !== want.dir) begin
						$error("direction: expected %0d, got %0d", want.dir,
							m_tdata[SCORE_BITS +: DIR_BITS]);
						fail_total++;
					end
					if (m_tlast !== want.done) begin
						$error("frame_done: expected %0b, got %0b", want.done, m_tlast);
						fail_total++;
					end
					if (m_tdata[23:SCORE_BITS+DIR_BITS] !== '0) begin
						$error("tdata pad: expected 0, got %0d",
							m_tdata[23:SCORE_BITS+DIR_BITS]);
						fail_total++;
					end
				end
			end

			// predict from an accepted sample
			if (s_tvalid && s_tready)
				advance_window(s_tdata, s_tuser);

			mismatches     <= fail_total;
			scores_waiting <= pending_scores.size();
			scores_checked <= checked_total;
		end
	end

endmodule

// ----- sim/directional_diff_score_test.sv -----
// ----------------------------------------------------------------------------
// directional_diff_score_test
// Drives sample frames and register settings into the directional score
// block: a small directed frame, extreme and clamped frame sizes, then random
// settings with random, mostly well-formed frames. A checker beside the block
// predicts and compares every score; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module directional_diff_score_test;
	import dds_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 260;
	localparam int QUIET_AFTER  = 210;
	localparam int LONG_HOLD    = 200;
	localparam int HOLD_AFTER   = 12;
	localparam int WIDE_PART    = 64;
	localparam int NARROW_LINES = 20;
	localparam int SETTLE       = 4;

	// corner values, ties and sign extremes
	localparam int DIRECTED_FRAME [25] = '{
		32767,  5,     0,  7,      32767,
		3,      32767, 9,  -32768, 2,
		1,      4,     32767, 4,   -1,
		6,      6,     6,  6,      6,
		32767,  0,     1,  0,      32767
	};
	localparam int EXTREME_SAMPLES [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [15:0] diff_sample
	logic        s_tuser;   // [0] frame_start
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [17:0] score, [20:18] direction, [23:21] zero
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int scores_waiting;
	int scores_checked;
	int cycle_count = 0;
	int samples_sent = 0;
	int settings_used = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	bit quiet = 1'b0;
	bit long_hold_armed = 1'b1;

	directional_diff_score uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	directional_diff_score_checker score_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .scores_waiting(scores_waiting),
		.scores_checked(scores_checked)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// abort a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Result side: random stalls, and one long hold-off so the block backs up
	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!arst_n) begin
				m_tready <= 1'b0;
				@(posedge clk);
			end else if (long_hold_armed && scores_checked >= HOLD_AFTER) begin
				long_hold_armed = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 99) < sink_idle_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Write one register: setup phase, access phase, then an idle phase
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic polarity, input int pref, input int cols,
			input int lines);
		write_reg(REG_POLARITY, 32'(polarity));
		write_reg(REG_PREF_DIR, 32'(pref));
		write_reg(REG_COLS, 32'(cols));
		write_reg(REG_LINES, 32'(lines));
		settings_used++;
		src_idle_pct  = $urandom_range(0, 2) * 15;
		sink_idle_pct = $urandom_range(0, 2) * 15;
	endtask

	// Offer one sample, with an optional random gap ahead of it
	task automatic send_sample(input sample_t value, input logic first);
		if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		samples_sent++;
	endtask

	// Drop valid, wait for every predicted score, then let the pipe settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (scores_waiting != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Small values make ties and every direction common; the rest spans the range
	function automatic sample_t pick_sample();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return sample_t'($urandom_range(0, 6) - 3);
		if (sel < 6)
			return sample_t'(EXTREME_SAMPLES[$urandom_range(0, 6)]);
		return sample_t'($urandom);
	endfunction

	function automatic int fit_dim(input int v, input int hi);
		return (v < MIN_SIZE) ? MIN_SIZE : (v > hi) ? hi : v;
	endfunction

	// Send frames of a fixed width; the first pixel of the first frame always starts a frame
	task automatic feed_frames(input int width, input int height, input int frames,
			input bit allow_cut);
		int  total;
		int  stop;
		bit  first;
		for (int f = 0; f < frames; f++) begin
			total = width * height;
			stop = (allow_cut && $urandom_range(0, 9) == 0) ?
				$urandom_range(1, total - 1) : total;
			for (int p = 0; p < stop; p++) begin
				if (p == 0)
					first = (f == 0) || $urandom_range(0, 1);
				else
					first = ($urandom_range(0, 99) == 0);
				send_sample(pick_sample(), first);
			end
		end
	endtask

	initial begin
		int random_base;
		int cols_reg;
		int lines_reg;
		int pref_reg;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed 5x5 frame
		set_mode(1'b1, DIR_DIAG_PL, 5, 5);
		for (int i = 0; i < 25; i++)
			send_sample(sample_t'(DIRECTED_FRAME[i]), i == 0);
		drain();

		// start of a line clamped to the widest size: no interior pixel yet
		set_mode(1'b0, DIR_HORZ, 2047, 0);
		for (int p = 0; p < WIDE_PART; p++)
			send_sample(pick_sample(), p == 0);
		drain();

		// narrowest line, clamped from below, in a frame of the greatest height
		set_mode(1'b1, DIR_DIAG_PR, 1, MAX_LINES);
		feed_frames(MIN_SIZE, NARROW_LINES, 1, 1'b0);
		drain();

		// random settings and frames
		random_base = samples_sent;
		while (samples_sent - random_base < RANDOM_ITEMS) begin
			quiet = (samples_sent - random_base >= QUIET_AFTER);
			cols_reg  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
				$urandom_range(3, 12);
			lines_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
				$urandom_range(3, 8);
			pref_reg  = ($urandom_range(0, 9) < 8) ? $urandom_range(DIR_DIAG_PL, DIR_HORZ) :
				$urandom_range(0, 7);
			set_mode(1'($urandom_range(0, 1)), pref_reg, cols_reg, lines_reg);
			feed_frames(fit_dim(cols_reg, MAX_COLS), fit_dim(lines_reg, MAX_LINES),
				$urandom_range(1, 3), 1'b1);
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d samples under %0d register settings, %0d scores compared.",
			samples_sent, settings_used, scores_checked);
		$display("Frames covered clamped sizes at both ends, cut frames and restarts.");
		if (mismatches == 0 && scores_waiting == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/dds_pkg.sv
hdl/dds_line_buf.sv
hdl/dds_score.sv
hdl/directional_diff_score.sv
sim/directional_diff_score_checker.sv
sim/directional_diff_score_test.sv
